// File: src/rgdd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgdd_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;
   localparam int COUNT_W     = 4;
   localparam int INDEX_W     = 3;
   localparam int OP_W        = 2;
   localparam int EDGE_W      = 2;
   localparam int CSR_INDEX_W = 1;

   localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
   localparam logic [OP_W-1:0] OP_GRANT   = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_REQUEST = 2'd1;
   localparam logic [EDGE_W-1:0] EDGE_HOLD    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_COUNT  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESOURCE_COUNT = 1'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_HOLDS,
      ST_REACH,
      ST_CLOSE,
      ST_DONE
   } rgdd_state_type;

   typedef struct packed {
      logic clear;
      logic load_hold;
      logic load_reach;
      logic close_step;
   } rgdd_clo_ctrl_type;

endpackage

`default_nettype wire

// File: src/rgdd_edge_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rgdd_edge_mem #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] row_valid_ff;
   logic [WIDTH-1:0] rd_q_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   // rows never written read as no edge
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

// File: src/rgdd_closure.sv
`timescale 1ns / 1ps
`default_nettype none

module rgdd_closure
   import rgdd_pkg::*;
#(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8
) (
   input  wire logic                                 clock,
   input  wire rgdd_clo_ctrl_type                    ctrl,
   input  wire logic [$clog2(MAX_PROCESSES)-1:0]     row_idx,
   input  wire logic [EDGE_W*MAX_RESOURCES-1:0]      row_data,
   input  wire logic [$clog2(MAX_RESOURCES+1)-1:0]   nr_eff,
   output logic                                      cycle_found
);

   logic [MAX_PROCESSES-1:0] holders_ff [MAX_RESOURCES];
   logic [MAX_PROCESSES-1:0] reach_ff   [MAX_PROCESSES];
   logic [MAX_RESOURCES-1:0] req_bits;
   logic [MAX_RESOURCES-1:0] hold_bits;
   logic [MAX_PROCESSES-1:0] reach_row_in;

   always_comb begin
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         req_bits[r]  = (32'(r) < 32'(nr_eff)) &&
                        (row_data[EDGE_W*r +: EDGE_W] == EDGE_REQUEST);
         hold_bits[r] = (32'(r) < 32'(nr_eff)) &&
                        (row_data[EDGE_W*r +: EDGE_W] == EDGE_HOLD);
      end
   end

   // processes the row waits on: holders of every resource it requests
   always_comb begin
      reach_row_in = '0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         if (req_bits[r]) begin
            reach_row_in = reach_row_in | holders_ff[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (ctrl.clear) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            holders_ff[r] <= '0;
         end
         for (int p = 0; p < MAX_PROCESSES; p++) begin
            reach_ff[p] <= '0;
         end
      end else if (ctrl.load_hold) begin
         for (int r = 0; r < MAX_RESOURCES; r++) begin
            holders_ff[r][row_idx] <= hold_bits[r];
         end
      end else if (ctrl.load_reach) begin
         reach_ff[row_idx] <= reach_row_in;
      end else if (ctrl.close_step) begin
         // one pivot of the transitive closure
         for (int p = 0; p < MAX_PROCESSES; p++) begin
            if (reach_ff[p][row_idx]) begin
               reach_ff[p] <= reach_ff[p] | reach_ff[row_idx];
            end
         end
      end else begin
      end
   end

   always_comb begin
      cycle_found = 1'b0;
      for (int p = 0; p < MAX_PROCESSES; p++) begin
         cycle_found = cycle_found | reach_ff[p][p];
      end
   end

endmodule

`default_nettype wire

// File: src/resource_graph_deadlock_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Deadlock detector over a process x resource allocation graph.
// req channel: one beat per request, grant or release of one edge.
// rsp channel: one beat per req beat, deadlock flag and index error flag.
// csr channel: writes process_count (index 0) or resource_count (index 1);
// always ready. The user must see that it is written only while no item is
// in flight; the block does not enforce this. Each beat rewrites one row of
// the edge memory (read in the accepting cycle, written in the next cycle),
// then the block makes two passes over the process rows of that memory,
// one row per cycle through its single read port, each pass ending once its
// last read has drained, and runs np pivot steps of a transitive closure on
// the wait-for matrix, np being the effective process count. req_tready
// returns when the result is posted. The result sits in an output register;
// req_tready returns while it waits, and a stalled rsp side holds only the
// finish of the next item.
// Reset empties the graph (all rows read as no edge), sets both counts
// to 5 and drops rsp_tvalid.

module resource_graph_deadlock_detector
   import rgdd_pkg::*;
#(
   parameter int MAX_PROCESSES = 8,
   parameter int MAX_RESOURCES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // operation [1:0], process_index [4:2], resource_index [7:5]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // deadlock [0], index_error [1], zero fill [7:2]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_data
);

   localparam int PW  = $clog2(MAX_PROCESSES);
   localparam int CPW = $clog2(MAX_PROCESSES + 1);
   localparam int CRW = $clog2(MAX_RESOURCES + 1);
   localparam int ROW_W = EDGE_W * MAX_RESOURCES;

   rgdd_state_type     state_ff, state_in;
   logic [COUNT_W-1:0] pcount_ff, rcount_ff;
   logic [CPW-1:0]     np_eff;
   logic [CRW-1:0]     nr_eff;

   logic [OP_W-1:0]    req_op;
   logic [INDEX_W-1:0] req_pi, req_ri;
   logic               req_err;
   logic               req_fire;

   logic [OP_W-1:0]    op_ff;
   logic [INDEX_W-1:0] pi_ff, ri_ff;
   logic               err_ff;

   logic [CPW-1:0]     cnt_ff, cnt_in;
   logic               pend_ff, pend_in;
   logic [PW-1:0]      pidx_ff, pidx_in;

   logic               mem_wr_en, mem_rd_en;
   logic [PW-1:0]      mem_rd_addr;
   logic [ROW_W-1:0]   mem_rd_data, new_row;
   logic [EDGE_W-1:0]  new_code;

   rgdd_clo_ctrl_type  clo_ctrl;
   logic [PW-1:0]      clo_idx;
   logic               cycle_found;

   logic               rsp_valid_ff, dl_ff, ie_ff;
   logic               rsp_free;
   logic               pass_done;
   logic               issue;

   assign req_op  = req_tdata[1:0];
   assign req_pi  = req_tdata[4:2];
   assign req_ri  = req_tdata[7:5];

   assign np_eff = (32'(pcount_ff) > 32'(MAX_PROCESSES)) ? CPW'(MAX_PROCESSES)
                                                         : CPW'(pcount_ff);
   assign nr_eff = (32'(rcount_ff) > 32'(MAX_RESOURCES)) ? CRW'(MAX_RESOURCES)
                                                         : CRW'(rcount_ff);
   assign req_err = (32'(req_pi) >= 32'(np_eff)) || (32'(req_ri) >= 32'(nr_eff));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign issue      = (cnt_ff < np_eff);
   assign pass_done  = !issue && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= COUNT_RESET;
         rcount_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_PROCESS_COUNT) begin
            pcount_ff <= csr_data;
         end else begin
            rcount_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_op;
         pi_ff  <= req_pi;
         ri_ff  <= req_ri;
         err_ff <= req_err;
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_REQUEST: new_code = EDGE_REQUEST;
         OP_GRANT:   new_code = EDGE_HOLD;
         default:    new_code = EDGE_NONE;
      endcase
      for (int r = 0; r < MAX_RESOURCES; r++) begin
         new_row[EDGE_W*r +: EDGE_W] = (32'(ri_ff) == 32'(r)) ? new_code
                                     : mem_rd_data[EDGE_W*r +: EDGE_W];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_HOLDS;
         ST_HOLDS:  if (pass_done) state_in = ST_REACH;
         ST_REACH:  if (pass_done) state_in = ST_CLOSE;
         ST_CLOSE:  if (!issue) state_in = ST_DONE;
         ST_DONE:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = cnt_ff[PW-1:0];
      mem_wr_en   = 1'b0;
      clo_ctrl    = '0;
      clo_idx     = pidx_ff;
      cnt_in      = cnt_ff;
      pend_in     = 1'b0;
      pidx_in     = pidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            mem_rd_en      = req_fire;
            mem_rd_addr    = PW'(32'(req_pi));
            clo_ctrl.clear = 1'b1;
            cnt_in         = '0;
         end
         ST_UPDATE: begin
            mem_wr_en = !err_ff && (op_ff != OP_UNUSED);
            cnt_in    = '0;
         end
         ST_HOLDS, ST_REACH: begin
            mem_rd_en = issue;
            pend_in   = issue;
            pidx_in   = cnt_ff[PW-1:0];
            if (state_ff == ST_HOLDS) begin
               clo_ctrl.load_hold = pend_ff;
            end else begin
               clo_ctrl.load_reach = pend_ff;
            end
            if (issue) begin
               cnt_in = cnt_ff + CPW'(1);
            end else if (pass_done) begin
               cnt_in = '0;
            end
         end
         ST_CLOSE: begin
            clo_ctrl.close_step = issue;
            clo_idx             = cnt_ff[PW-1:0];
            if (issue) begin
               cnt_in = cnt_ff + CPW'(1);
            end
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pidx_ff <= pidx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         dl_ff <= cycle_found;
         ie_ff <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W-2)'(0), ie_ff, dl_ff};

   rgdd_edge_mem #(
      .DEPTH (MAX_PROCESSES),
      .WIDTH (ROW_W)
   ) u_edge_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (PW'(32'(pi_ff))),
      .wr_data (new_row),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rgdd_closure #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .MAX_RESOURCES (MAX_RESOURCES)
   ) u_closure (
      .clock       (clock),
      .ctrl        (clo_ctrl),
      .row_idx     (clo_idx),
      .row_data    (mem_rd_data),
      .nr_eff      (nr_eff),
      .cycle_found (cycle_found)
   );

endmodule

`default_nettype wire

// File: src/rgdd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rgdd_checker
   import rgdd_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("req accepted again before the search finished");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:2] == '0))
      else $error("rsp fill bits not zero");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready && csr_ready)
      else $error("outputs not in reset state");

endmodule

bind resource_graph_deadlock_detector rgdd_checker u_rgdd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

`default_nettype wire
